/* rtl/teg_pkg.sv */
`timescale 1ns / 1ps
// teg_pkg: types, constants and the sine polynomial coefficients of the
// tone envelope generator. No dependencies.

package teg_pkg;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam logic [CFG_AW-1:0] REG_PHASE_STEP     = 3'd0;
	localparam logic [CFG_AW-1:0] REG_NOTE_LENGTH    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_AMPLITUDE      = 3'd2;
	localparam logic [CFG_AW-1:0] REG_ATTACK_LENGTH  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_RELEASE_LENGTH = 3'd4;

	// register widths and reset values
	localparam int STEP_W = 32;
	localparam int NOTE_W = 20;
	localparam int AMP_W  = 15;
	localparam int ENV_W  = 16;

	localparam logic [NOTE_W-1:0] NOTE_RST    = 20'd1764;
	localparam logic [AMP_W-1:0]  AMP_RST     = 15'd7209;
	localparam logic [ENV_W-1:0]  ATTACK_RST  = 16'd88;
	localparam logic [ENV_W-1:0]  RELEASE_RST = 16'd1544;

	// sample path
	localparam int SAMPLE_W = 16;
	localparam logic [AMP_W-1:0] SINE_MAX = 15'h7fff;

	// shared multiplier
	localparam int MUL_W = 32;

	// serial divider: 64-bit numerator, 47-bit divisor, 32-bit quotient
	localparam int NUM_W     = 64;
	localparam int DEN_W     = 47;
	localparam int QUO_W     = 32;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	// Q30 taylor coefficients of sin(pi/2 * z)
	localparam logic [30:0] SC1 = 31'd1686629713;
	localparam logic [30:0] SC3 = 31'd693598668;
	localparam logic [30:0] SC5 = 31'd85569306;
	localparam logic [30:0] SC7 = 31'd5026995;
	localparam logic [30:0] SC9 = 31'd172272;

	// horner order after the leading term
	function automatic logic [30:0] poly_coef(input logic [1:0] term);
		logic [30:0] c;
		case (term)
			2'd0: c = SC7;
			2'd1: c = SC5;
			2'd2: c = SC3;
			default: c = SC1;
		endcase
		return c;
	endfunction

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_MULK,
		OP_QUAD,
		OP_ZLO,
		OP_ZHI,
		OP_LATZ,
		OP_Z2,
		OP_Z2L,
		OP_PMUL,
		OP_PSUB,
		OP_SMUL,
		OP_SCALE,
		OP_EMUL,
		OP_AMUL,
		OP_NMUL,
		OP_DMUL,
		OP_DIVE,
		OP_OUT_NOTE,
		OP_OUT_IDLE
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MULK,
		ST_QUAD,
		ST_ZLO,
		ST_ZHI,
		ST_LATZ,
		ST_Z2,
		ST_Z2L,
		ST_PMUL,
		ST_PSUB,
		ST_SMUL,
		ST_SCALE,
		ST_EMUL,
		ST_AMUL,
		ST_NMUL,
		ST_DMUL,
		ST_DIVE,
		ST_DIVW,
		ST_OUT,
		ST_OUTI
	} ctrl_state_t;

	typedef struct packed {
		logic play_next;
		logic div_busy;
		logic term_last;
	} dp_status_t;

endpackage

/* rtl/tone_envelope_generator.sv */
`timescale 1ns / 1ps
// tone_envelope_generator: top level, sine oscillator with linear attack and
// release envelope. Depends on teg_pkg, teg_ctrl and teg_dp.

// Each accepted request is one sample tick; restart set begins the note at
// sample zero, phase zero. After a note request is accepted, 21 sequencer
// steps run (phase to table index, reciprocal scaling of the quarter
// position, the degree-nine sine polynomial and the envelope products on
// the shared 32x32 multiplier), then the radix-2 divider is started, the
// sequencer waits on the envelope quotient, and the output register is
// loaded. An idle tick goes from acceptance straight to its load. The next
// request is taken the cycle after the load; a held result stalls the
// sequencer only when the next result is ready to load. The sine is
// computed per sample from its polynomial, so no table memory is used and
// there is no clearing pass after reset. Registers are to be written by the
// user through cfg_we/cfg_addr/cfg_wdata only while no request is in work;
// the block itself does not enforce this.

module tone_envelope_generator
	import teg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int INDEX_WIDTH      = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       restart,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       last,
	output logic                       active,
	input  logic                       cfg_we,
	input  logic [CFG_AW-1:0]          cfg_addr,
	input  logic [CFG_DW-1:0]          cfg_wdata
);

	dp_op_t              op;
	dp_status_t          status;
	logic [SAMPLE_W-1:0] sample_w;

	teg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.op        (op)
	);

	teg_dp #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.INDEX_WIDTH      (INDEX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.restart   (restart),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.sample    (sample_w),
		.last      (last),
		.active    (active)
	);

	assign sample = $signed(sample_w);

endmodule

/* rtl/teg_div.sv */
`timescale 1ns / 1ps
// teg_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on teg_pkg; the quotient must be below 2^QUO_W.

module teg_div
	import teg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] low_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	assign trial = {rem_q, low_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = cnt_q != '0;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num[NUM_W-1:QUO_W]);
			low_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

endmodule

/* rtl/teg_dp.sv */
`timescale 1ns / 1ps
// teg_dp: configuration registers, note state, shared multiplier, sine
// polynomial and envelope datapath. Depends on teg_pkg and teg_div.

module teg_dp
	import teg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int INDEX_WIDTH      = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_op_t              op,
	input  logic                restart,
	input  logic                cfg_we,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [CFG_DW-1:0]   cfg_wdata,
	output dp_status_t          status,
	output logic [SAMPLE_W-1:0] sample,
	output logic                last,
	output logic                active
);

	localparam int KW = $clog2(SINE_TABLE_DEPTH);
	localparam int UW = KW + 2;
	localparam int RW = KW + 1;
	localparam int EW = ((INDEX_WIDTH > NOTE_W) ? INDEX_WIDTH : NOTE_W) + 1;
	localparam logic [UW-1:0] D1 = UW'(SINE_TABLE_DEPTH);
	localparam logic [UW-1:0] D2 = UW'(2 * SINE_TABLE_DEPTH);
	localparam logic [UW-1:0] D3 = UW'(3 * SINE_TABLE_DEPTH);

	// rounded-up reciprocal of the depth, exact for quarter positions up to the depth
	localparam int ZS = 2 * KW;
	localparam logic [63:0] ZM = ((64'd1 << (30 + ZS)) + 64'(SINE_TABLE_DEPTH - 1))
		/ 64'(SINE_TABLE_DEPTH);

	// configuration
	logic [STEP_W-1:0] phase_step_q;
	logic [NOTE_W-1:0] note_q;
	logic [AMP_W-1:0]  amp_q;
	logic [ENV_W-1:0]  att_q;
	logic [ENV_W-1:0]  rel_q;

	// note state
	logic [STEP_W-1:0]      phase_q;
	logic [INDEX_WIDTH-1:0] idx_q;
	logic                   playing_q;
	logic [1:0]             term_q;

	// working registers
	logic [2*MUL_W-1:0] mul_q;
	logic [NUM_W-1:0]   num_q;
	logic [MUL_W-1:0]   eaer_q;
	logic [RW-1:0]      r_q;
	logic [2*MUL_W-1:0] zlo_q;
	logic [30:0]        z_q;
	logic [30:0]        z2_q;
	logic [30:0]        p_q;
	logic [AMP_W-1:0]   sine_q;
	logic               neg_q;

	logic [SAMPLE_W-1:0] sample_q;
	logic                last_q;
	logic                active_q;

	logic             mul_en;
	logic [MUL_W-1:0] mul_a;
	logic [MUL_W-1:0] mul_b;

	logic [KW-1:0] k;
	logic [UW-1:0] u;
	logic [UW-1:0] urem;
	logic [UW-1:0] rfold;
	logic [1:0]    quad;
	logic [63:0]   zsum;

	logic [31:0] psub;
	logic [31:0] s;
	logic [47:0] sc_w;
	logic [17:0] sc_hi;
	logic [AMP_W-1:0] sine_w;

	logic [EW-1:0]    i_ext;
	logic [EW-1:0]    n_ext;
	logic [EW-1:0]    ndiff;
	logic             attack_on;
	logic             rel_on;
	logic             last_w;
	logic [ENV_W-1:0] ea;
	logic [ENV_W-1:0] er;
	logic [ENV_W-1:0] ad;
	logic [ENV_W-1:0] rd;

	logic             div_start;
	logic [DEN_W-1:0] env_den;
	logic             div_busy;
	logic [QUO_W-1:0] div_quo;

	logic [SAMPLE_W-1:0] mag;

	// phase to quadrant and folded quarter position
	assign k = mul_q[MUL_W +: KW];
	assign u = {k, 2'b00};

	always_comb begin
		if (u >= D3) begin
			quad = 2'd3;
			urem = u - D3;
		end else if (u >= D2) begin
			quad = 2'd2;
			urem = u - D2;
		end else if (u >= D1) begin
			quad = 2'd1;
			urem = u - D1;
		end else begin
			quad = 2'd0;
			urem = u;
		end
		rfold = quad[0] ? (D1 - urem) : urem;
	end

	// quarter position times the reciprocal, high partial product in mul_q
	assign zsum = {mul_q[MUL_W-1:0], 32'b0} + zlo_q;

	// polynomial step and final scaling to q0.15
	assign psub   = {1'b0, poly_coef(term_q)} - mul_q[61:30];
	assign s      = mul_q[61:30];
	assign sc_w   = {1'b0, s, 15'b0} - {16'b0, s} + 48'h0000_2000_0000;
	assign sc_hi  = sc_w[47:30];
	assign sine_w = (sc_hi > {3'b000, SINE_MAX}) ? SINE_MAX : sc_hi[AMP_W-1:0];

	// envelope factors
	assign i_ext     = EW'(idx_q);
	assign n_ext     = EW'(note_q);
	assign ndiff     = n_ext - i_ext;
	assign attack_on = (att_q != '0) && (i_ext < EW'(att_q));
	assign rel_on    = (rel_q != '0) && ((i_ext + EW'(rel_q)) > n_ext);
	assign ea        = attack_on ? i_ext[ENV_W-1:0] : ENV_W'(1);
	assign ad        = attack_on ? att_q : ENV_W'(1);
	assign er        = rel_on ? ((n_ext > i_ext) ? ndiff[ENV_W-1:0] : '0) : ENV_W'(1);
	assign rd        = rel_on ? rel_q : ENV_W'(1);
	assign last_w    = ((i_ext + EW'(1)) >= n_ext) || (idx_q == '1);

	// divider operands
	assign env_den   = {mul_q[MUL_W-1:0], 15'b0} - {15'b0, mul_q[MUL_W-1:0]};
	assign div_start = (op == OP_DIVE);

	teg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (env_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign mag = {1'b0, div_quo[AMP_W-1:0]};

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (op)
			OP_MULK: begin
				mul_a = phase_q;
				mul_b = MUL_W'(SINE_TABLE_DEPTH);
			end
			OP_ZLO: begin
				mul_a = MUL_W'(r_q);
				mul_b = ZM[MUL_W-1:0];
			end
			OP_ZHI: begin
				mul_a = MUL_W'(r_q);
				mul_b = ZM[2*MUL_W-1:MUL_W];
			end
			OP_Z2: begin
				mul_a = MUL_W'(z_q);
				mul_b = MUL_W'(z_q);
			end
			OP_PMUL: begin
				mul_a = MUL_W'(z2_q);
				mul_b = MUL_W'(p_q);
			end
			OP_SMUL: begin
				mul_a = MUL_W'(z_q);
				mul_b = MUL_W'(p_q);
			end
			OP_EMUL: begin
				mul_a = MUL_W'(ea);
				mul_b = MUL_W'(er);
			end
			OP_AMUL: begin
				mul_a = MUL_W'(amp_q);
				mul_b = MUL_W'(sine_q);
			end
			OP_NMUL: begin
				mul_a = eaer_q;
				mul_b = mul_q[MUL_W-1:0];
			end
			OP_DMUL: begin
				mul_a = MUL_W'(ad);
				mul_b = MUL_W'(rd);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// configuration and note state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			note_q       <= NOTE_RST;
			amp_q        <= AMP_RST;
			att_q        <= ATTACK_RST;
			rel_q        <= RELEASE_RST;
			phase_q      <= '0;
			idx_q        <= '0;
			playing_q    <= 1'b0;
			term_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_PHASE_STEP:     phase_step_q <= cfg_wdata[STEP_W-1:0];
					REG_NOTE_LENGTH:    note_q       <= cfg_wdata[NOTE_W-1:0];
					REG_AMPLITUDE:      amp_q        <= cfg_wdata[AMP_W-1:0];
					REG_ATTACK_LENGTH:  att_q        <= cfg_wdata[ENV_W-1:0];
					REG_RELEASE_LENGTH: rel_q        <= cfg_wdata[ENV_W-1:0];
					default: ;
				endcase
			end
			case (op)
				OP_ACCEPT: begin
					if (restart) begin
						phase_q   <= '0;
						idx_q     <= '0;
						playing_q <= note_q != '0;
					end
				end
				OP_Z2L: begin
					term_q <= '0;
				end
				OP_PSUB: begin
					term_q <= term_q + 2'd1;
				end
				OP_OUT_NOTE: begin
					phase_q <= phase_q + phase_step_q;
					idx_q   <= idx_q + INDEX_WIDTH'(1);
					if (last_w) begin
						playing_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= mul_a * mul_b;
		end
		case (op)
			OP_QUAD: begin
				neg_q <= quad[1];
				r_q   <= rfold[RW-1:0];
			end
			OP_ZHI:   zlo_q  <= mul_q;
			OP_LATZ:  z_q    <= zsum[ZS +: 31];
			OP_Z2L: begin
				z2_q <= mul_q[60:30];
				p_q  <= SC9;
			end
			OP_PSUB:  p_q    <= psub[30:0];
			OP_SCALE: sine_q <= sine_w;
			OP_AMUL:  eaer_q <= mul_q[MUL_W-1:0];
			OP_DMUL:  num_q  <= mul_q;
			OP_OUT_NOTE: begin
				sample_q <= neg_q ? (-mag) : mag;
				last_q   <= last_w;
				active_q <= 1'b1;
			end
			OP_OUT_IDLE: begin
				sample_q <= '0;
				last_q   <= 1'b0;
				active_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign status.play_next = restart ? (note_q != '0) : playing_q;
	assign status.div_busy  = div_busy;
	assign status.term_last = term_q == 2'd3;

	assign sample = sample_q;
	assign last   = last_q;
	assign active = active_q;

endmodule

/* rtl/teg_ctrl.sv */
`timescale 1ns / 1ps
// teg_ctrl: sequencer of the tone envelope generator, handshakes and
// datapath commands. Depends on teg_pkg.

module teg_ctrl
	import teg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_op_t     op
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        load;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_ACCEPT;
					state_d = status.play_next ? ST_MULK : ST_OUTI;
				end
			end
			ST_MULK: begin
				op      = OP_MULK;
				state_d = ST_QUAD;
			end
			ST_QUAD: begin
				op      = OP_QUAD;
				state_d = ST_ZLO;
			end
			ST_ZLO: begin
				op      = OP_ZLO;
				state_d = ST_ZHI;
			end
			ST_ZHI: begin
				op      = OP_ZHI;
				state_d = ST_LATZ;
			end
			ST_LATZ: begin
				op      = OP_LATZ;
				state_d = ST_Z2;
			end
			ST_Z2: begin
				op      = OP_Z2;
				state_d = ST_Z2L;
			end
			ST_Z2L: begin
				op      = OP_Z2L;
				state_d = ST_PMUL;
			end
			ST_PMUL: begin
				op      = OP_PMUL;
				state_d = ST_PSUB;
			end
			ST_PSUB: begin
				op      = OP_PSUB;
				state_d = status.term_last ? ST_SMUL : ST_PMUL;
			end
			ST_SMUL: begin
				op      = OP_SMUL;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				op      = OP_SCALE;
				state_d = ST_EMUL;
			end
			ST_EMUL: begin
				op      = OP_EMUL;
				state_d = ST_AMUL;
			end
			ST_AMUL: begin
				op      = OP_AMUL;
				state_d = ST_NMUL;
			end
			ST_NMUL: begin
				op      = OP_NMUL;
				state_d = ST_DMUL;
			end
			ST_DMUL: begin
				op      = OP_DMUL;
				state_d = ST_DIVE;
			end
			ST_DIVE: begin
				op      = OP_DIVE;
				state_d = ST_DIVW;
			end
			ST_DIVW: begin
				if (!status.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (slot_free) begin
					op      = OP_OUT_NOTE;
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_OUTI: begin
				if (slot_free) begin
					op      = OP_OUT_IDLE;
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/teg_checker.sv */
`timescale 1ns / 1ps
// teg_checker: port-level assertions for tone_envelope_generator, bound to
// the top level below. Depends on teg_pkg.

module teg_port_props
	import teg_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       restart,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] sample,
	input logic                       last,
	input logic                       active,
	input logic                       cfg_we,
	input logic [CFG_AW-1:0]          cfg_addr,
	input logic [CFG_DW-1:0]          cfg_wdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last)
			&& $stable(active))
		else $error("stalled result changed");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> sample == '0 && !last)
		else $error("idle result not zero");

	a_last_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> active)
		else $error("last without active");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active |-> sample != 16'sh8000)
		else $error("sample out of range");

endmodule

bind tone_envelope_generator teg_port_props u_teg_port_props (.*);
